FILE: sv/dtc_pkg.sv
// Shared types and constants for the device tick timestamp converter.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package dtc_pkg;

  typedef logic [1:0] cmd_code_t;
  localparam cmd_code_t CMD_UPDATE  = 2'd0;
  localparam cmd_code_t CMD_CALIB   = 2'd1;
  localparam cmd_code_t CMD_CONVERT = 2'd2;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_COUNTER_BITS = 2'd0;
  localparam cfg_idx_t CFG_TICK_MULT    = 2'd1;
  localparam cfg_idx_t CFG_TICK_SHIFT   = 2'd2;

  localparam logic [20:0] USEC_PER_SEC   = 21'd1000000;
  localparam logic [19:0] USEC_MAX       = 20'd999999;
  localparam logic [31:0] REF_MOVE_SEC   = 32'd4200;
  // floor(2^38 / 15625); 1000000 = 64 * 15625
  localparam logic [24:0] RECIP_15625    = 25'd17592186;

  localparam logic [5:0]  RST_COUNTER_BITS = 6'd32;
  localparam logic [31:0] RST_TICK_MULT    = 32'd1;
  localparam logic [5:0]  RST_TICK_SHIFT   = 6'd0;

  typedef struct packed {
    cmd_code_t   command;
    logic [31:0] device_ts;
    logic [31:0] host_sec;
    logic [19:0] host_usec;
  } in_item_t;

  typedef struct packed {
    logic [31:0] time_sec;
    logic [19:0] time_usec;
    logic        from_host_clock;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic mul;
    logic shf;
    logic qest;
    logic rem;
    logic fix;
    logic fin_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_convert;
    logic calibrated;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: sv/device_tick_timestamp_converter.sv
// Device tick to host time converter, top level.
// One item in work at a time. Update, calibration and unused items pass through accept and execute.
// A convert passes through accept, execute, multiply, shift, reciprocal quotient, remainder,
// fix-up and result load; out_valid rises with the loaded result. A convert before the first
// calibration skips from execute to result load. A waiting result holds a later convert at load.
// Reset (rst_n, synchronous, active low) clears FSM and converter state; loads register defaults.
`default_nettype none

module device_tick_timestamp_converter (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  dtc_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output dtc_pkg::out_item_t    out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  dtc_pkg::cfg_idx_t     cfg_index,
  input  wire  [31:0]           cfg_data
);
  import dtc_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  assign cfg_ready = 1'b1;

  dtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  dtc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: sv/dtc_datapath.sv
// Datapath: configuration registers, converter state, and the convert pipeline
// (multiply, shift, divide by one million, carry). Depends on dtc_pkg.
`default_nettype none

module dtc_datapath (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_valid,
  input  dtc_pkg::cfg_idx_t     cfg_index,
  input  wire  [31:0]           cfg_data,
  input  dtc_pkg::in_item_t     in_data,
  input  dtc_pkg::dp_cmd_t      cmd,
  output dtc_pkg::dp_sts_t      sts,
  output dtc_pkg::out_item_t    out_data
);
  import dtc_pkg::*;

  function automatic logic [31:0] wrap_mask(input logic [5:0] bits);
    logic [31:0] m;
    if (bits >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = (32'd1 << bits[4:0]) - 32'd1;
    end
    return m;
  endfunction

  function automatic logic [31:0] tick_gap(input logic [31:0] now, input logic [31:0] prior,
                                           input logic [31:0] mask);
    logic [31:0] d;
    d = now - prior;
    if (now < prior) begin
      d = d & mask;
    end
    return d;
  endfunction

  // configuration
  logic [5:0]  counter_bits_r;
  logic [31:0] mult_r;
  logic [5:0]  shift_r;

  // latched item
  cmd_code_t   cmd_r;
  logic [31:0] ts_r;
  logic [31:0] hs_r;
  logic [19:0] hu_r;

  // converter state
  logic [31:0] ref_sec_r, ref_sec_nxt;
  logic [19:0] ref_usec_r, ref_usec_nxt;
  logic [31:0] last_cal_sec_r, last_cal_sec_nxt;
  logic [19:0] last_cal_usec_r, last_cal_usec_nxt;
  logic [31:0] prev_ticks_r, prev_ticks_nxt;
  logic [31:0] cur_ticks_r, cur_ticks_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] cal_count_r, cal_count_nxt;

  // convert pipeline
  logic [32:0] acc_r;
  logic [63:0] prod_r;
  logic [31:0] us_r;
  logic [12:0] q_r;
  logic [20:0] rem_r;
  logic [12:0] qf_r;
  logic [19:0] remf_r;
  out_item_t   out_r;

  logic [31:0] mask;
  logic [31:0] tot_base;
  logic [63:0] full;
  logic [63:0] shifted;
  logic [50:0] qprod;
  logic [32:0] qmul;
  logic [32:0] rem_diff;
  logic [20:0] usec_sum;
  logic        usec_carry;
  logic [20:0] usec_fin;

  assign mask = wrap_mask(counter_bits_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_bits_r <= RST_COUNTER_BITS;
      mult_r         <= RST_TICK_MULT;
      shift_r        <= RST_TICK_SHIFT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COUNTER_BITS: counter_bits_r <= cfg_data[5:0];
        CFG_TICK_MULT:    mult_r         <= cfg_data;
        CFG_TICK_SHIFT:   shift_r        <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // latch the item, clamping microseconds
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_data.command;
      ts_r  <= in_data.device_ts;
      hs_r  <= in_data.host_sec;
      hu_r  <= (in_data.host_usec > USEC_MAX) ? USEC_MAX : in_data.host_usec;
    end
  end

  always_comb begin
    ref_sec_nxt       = ref_sec_r;
    ref_usec_nxt      = ref_usec_r;
    last_cal_sec_nxt  = last_cal_sec_r;
    last_cal_usec_nxt = last_cal_usec_r;
    prev_ticks_nxt    = prev_ticks_r;
    cur_ticks_nxt     = cur_ticks_r;
    total_nxt         = total_r;
    cal_count_nxt     = cal_count_r;
    tot_base          = total_r;
    if (cmd.exec) begin
      case (cmd_r)
        CMD_UPDATE: begin
          cur_ticks_nxt = ts_r;
          if (last_cal_sec_r != 32'd0) begin
            total_nxt = total_r + tick_gap(ts_r, prev_ticks_r, mask);
          end
        end
        CMD_CALIB: begin
          if (ref_sec_r == 32'd0) begin
            ref_sec_nxt      = hs_r;
            ref_usec_nxt     = hu_r;
            last_cal_sec_nxt = 32'd0;
          end else begin
            // move the reference after a long gap and restart the total
            if (last_cal_sec_r != 32'd0 && (last_cal_sec_r - ref_sec_r) > REF_MOVE_SEC) begin
              ref_sec_nxt  = last_cal_sec_r;
              ref_usec_nxt = last_cal_usec_r;
              tot_base     = 32'd0;
            end
            last_cal_sec_nxt  = hs_r;
            last_cal_usec_nxt = hu_r;
            cal_count_nxt     = cal_count_r + 32'd1;
          end
          prev_ticks_nxt = cur_ticks_r;
          cur_ticks_nxt  = ts_r;
          if (last_cal_sec_nxt != 32'd0) begin
            total_nxt = tot_base + tick_gap(ts_r, cur_ticks_r, mask);
          end else begin
            total_nxt = tot_base;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_sec_r       <= '0;
      ref_usec_r      <= '0;
      last_cal_sec_r  <= '0;
      last_cal_usec_r <= '0;
      prev_ticks_r    <= '0;
      cur_ticks_r     <= '0;
      total_r         <= '0;
      cal_count_r     <= '0;
    end else begin
      ref_sec_r       <= ref_sec_nxt;
      ref_usec_r      <= ref_usec_nxt;
      last_cal_sec_r  <= last_cal_sec_nxt;
      last_cal_usec_r <= last_cal_usec_nxt;
      prev_ticks_r    <= prev_ticks_nxt;
      cur_ticks_r     <= cur_ticks_nxt;
      total_r         <= total_nxt;
      cal_count_r     <= cal_count_nxt;
    end
  end

  // bit 32 of the sum contributes multiplier << 32 to the wrapped product
  assign full    = prod_r + {(acc_r[32] ? mult_r : 32'd0), 32'd0};
  assign shifted = full >> shift_r;
  // quotient estimate is exact or one low
  assign qprod    = {25'd0, us_r[31:6]} * {26'd0, RECIP_15625};
  assign qmul     = {20'd0, q_r} * {12'd0, USEC_PER_SEC};
  assign rem_diff = {1'b0, us_r} - qmul;

  assign usec_sum   = {1'b0, ref_usec_r} + {1'b0, remf_r};
  assign usec_carry = (usec_sum >= USEC_PER_SEC);
  assign usec_fin   = usec_carry ? (usec_sum - USEC_PER_SEC) : usec_sum;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc_r <= {1'b0, tick_gap(ts_r, cur_ticks_r, mask)} + {1'b0, total_r};
    end
    if (cmd.mul) begin
      prod_r <= {32'd0, acc_r[31:0]} * {32'd0, mult_r};
    end
    if (cmd.shf) begin
      us_r <= shifted[31:0];
    end
    if (cmd.qest) begin
      q_r <= qprod[50:38];
    end
    if (cmd.rem) begin
      rem_r <= rem_diff[20:0];
    end
    if (cmd.fix) begin
      if (rem_r >= USEC_PER_SEC) begin
        remf_r <= 20'(rem_r - USEC_PER_SEC);
        qf_r   <= q_r + 13'd1;
      end else begin
        remf_r <= rem_r[19:0];
        qf_r   <= q_r;
      end
    end
    if (cmd.fin_load) begin
      if (last_cal_sec_r == 32'd0) begin
        out_r.time_sec        <= hs_r;
        out_r.time_usec       <= hu_r;
        out_r.from_host_clock <= 1'b1;
      end else begin
        out_r.time_sec        <= ref_sec_r + {19'd0, qf_r} + {31'd0, usec_carry};
        out_r.time_usec       <= usec_fin[19:0];
        out_r.from_host_clock <= 1'b0;
      end
    end
  end

  assign sts.is_convert = (cmd_r == CMD_CONVERT);
  assign sts.calibrated = (last_cal_sec_r != 32'd0);
  assign out_data       = out_r;

endmodule

`default_nettype wire

FILE: sv/dtc_ctrl.sv
// Controller: sequences one item at a time through the datapath and owns
// the input stall and the output valid. Depends on dtc_pkg.
`default_nettype none

module dtc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  input  dtc_pkg::dp_sts_t    sts,
  output dtc_pkg::dp_cmd_t    cmd
);
  import dtc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_MUL, ST_SHF, ST_QEST, ST_REM, ST_FIX, ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.load_in  = (state_r == ST_IDLE) && in_valid;
    cmd.exec     = (state_r == ST_EXEC);
    cmd.mul      = (state_r == ST_MUL);
    cmd.shf      = (state_r == ST_SHF);
    cmd.qest     = (state_r == ST_QEST);
    cmd.rem      = (state_r == ST_REM);
    cmd.fix      = (state_r == ST_FIX);
    cmd.fin_load = (state_r == ST_FIN) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (!sts.is_convert) begin
          state_nxt = ST_IDLE;
        end else if (sts.calibrated) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_MUL:  state_nxt = ST_SHF;
      ST_SHF:  state_nxt = ST_QEST;
      ST_QEST: state_nxt = ST_REM;
      ST_REM:  state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_FIN;
      // hold until the output register is free
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
